// ----- hw/rtl/angle_window_trigger_lockout_assert.svh -----
// Assertion macros for the angle window trigger block.
// Included by angle_window_trigger_lockout.sv; depends on nothing else.
`ifndef ANGLE_WINDOW_TRIGGER_LOCKOUT_ASSERT_SVH
`define ANGLE_WINDOW_TRIGGER_LOCKOUT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define AWTL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("awtl: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define AWTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("awtl: next-cycle check failed");

`endif

// ----- hw/rtl/awtl_pkg.sv -----
// Types and constants for the angle window trigger block.
// No dependencies; imported by angle_window_trigger_lockout.
package awtl_pkg;

    // Item kinds
    localparam logic CmdSample = 1'b0;
    localparam logic CmdTick   = 1'b1;

    // Register map, index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_TARGET_ANGLE    = 2'd0,
        REG_RATE_SIGN       = 2'd1,
        REG_REARM_MS        = 2'd2,
        REG_TOLERANCE_CENTI = 2'd3
    } awtl_reg_t;

    localparam int unsigned AddrWidth = 4;

    // Widths of registers and state
    localparam int unsigned TargetWidth = 9;
    localparam int unsigned MsWidth     = 10;

    // Fixed-point scaling: angle_raw*180*100 vs (centre +/- tol) << 15
    localparam int unsigned FullScaleShift = 15;
    localparam logic signed [31:0] AngleScale  = 32'sd18000;
    localparam logic signed [15:0] CentiPerDeg = 16'sd100;

    // Reset values and limits
    localparam logic signed [TargetWidth-1:0] TargetReset = 9'sd30;
    localparam logic                          RateSignReset = 1'b1;
    localparam logic [MsWidth-1:0]            RearmReset = 10'd500;
    localparam logic [MsWidth-1:0]            RearmMin   = 10'd20;
    localparam logic [MsWidth-1:0]            TolReset   = 10'd50;

    typedef struct packed {
        logic               command;
        logic signed [15:0] rate_raw;
        logic signed [15:0] angle_raw;
    } awtl_item_t;

    typedef struct packed {
        logic fire;
        logic armed_now;
    } awtl_result_t;

endpackage

// ----- hw/rtl/angle_window_trigger_lockout.sv -----
// Angle window trigger with millisecond lockout, top level.
// Depends on awtl_pkg and angle_window_trigger_lockout_assert.svh.
//
//  channel  | direction | handshake                    | beat
//  ---------+-----------+------------------------------+-----------------------------
//  sample   | in        | sample_valid / sample_stall  | awtl_item_t (sample or tick)
//  result   | out       | result_valid / result_stall  | awtl_result_t (fire, armed)
//  apb      | in/out    | psel / penable / pready      | 32-bit register write/read
//
// One beat per cycle while the result is not stalled; a result is registered
// after its beat is taken (item register, then result register).
// The window compare and lockout update sit between those two registers.
// Reset (rst_n low): armed, lockout at zero, registers at their defaults.
// A stalled result holds the pipe; the item register still takes a beat
// when it is empty.

`include "angle_window_trigger_lockout_assert.svh"

module angle_window_trigger_lockout (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  awtl_pkg::awtl_item_t               sample,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output awtl_pkg::awtl_result_t             result,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [awtl_pkg::AddrWidth-1:0]     paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import awtl_pkg::*;

    // Configuration registers
    logic signed [TargetWidth-1:0] target_reg;
    logic                          rate_sign_reg;
    logic [MsWidth-1:0]            rearm_reg;
    logic [MsWidth-1:0]            tol_reg;

    // Block state
    logic               armed_reg, armed_next;
    logic [MsWidth-1:0] lockout_reg, lockout_next;

    // Pipeline registers
    logic         item_valid_reg;
    awtl_item_t   item_reg;
    logic         result_valid_reg;
    awtl_result_t result_reg;
    awtl_result_t result_next;

    logic      item_advance;
    logic      cfg_write;
    awtl_reg_t cfg_index;

    // Window compare terms
    logic signed [31:0] scaled;
    logic signed [15:0] centre;
    logic signed [15:0] hi_centi;
    logic signed [15:0] lo_centi;
    logic signed [31:0] hi_bound;
    logic signed [31:0] lo_bound;
    logic               sign_ok;
    logic               in_window;
    logic               fire;
    logic [MsWidth-1:0] lockout_dec;

    // APB decode
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = awtl_reg_t'(paddr[AddrWidth-1:2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_TARGET_ANGLE:    prdata = 32'($signed(target_reg));
            REG_RATE_SIGN:       prdata = {31'd0, rate_sign_reg};
            REG_REARM_MS:        prdata = {22'd0, rearm_reg};
            REG_TOLERANCE_CENTI: prdata = {22'd0, tol_reg};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= TargetReset;
            rate_sign_reg <= RateSignReset;
            rearm_reg     <= RearmReset;
            tol_reg       <= TolReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_ANGLE:    target_reg    <= $signed(pwdata[TargetWidth-1:0]);
                REG_RATE_SIGN:       rate_sign_reg <= pwdata[0];
                REG_REARM_MS:
                begin
                    // short lockouts saturate to the minimum
                    if (pwdata[MsWidth-1:0] < RearmMin)
                        rearm_reg <= RearmMin;
                    else
                        rearm_reg <= pwdata[MsWidth-1:0];
                end
                REG_TOLERANCE_CENTI: tol_reg       <= pwdata[MsWidth-1:0];
                default:             ;
            endcase
        end
    end

    // Handshake: item register moves on when the result register is free
    assign item_advance = !result_valid_reg || !result_stall;
    assign sample_stall = item_valid_reg && !item_advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Window in 0.01 degree units, scaled by 2^15
    assign scaled   = $signed({{16{item_reg.angle_raw[15]}}, item_reg.angle_raw}) * AngleScale;
    assign centre   = $signed({{(16-TargetWidth){target_reg[TargetWidth-1]}}, target_reg})
                      * CentiPerDeg;
    assign hi_centi = centre + $signed({{(16-MsWidth){1'b0}}, tol_reg});
    assign lo_centi = centre - $signed({{(16-MsWidth){1'b0}}, tol_reg});
    assign hi_bound = $signed({hi_centi[15], hi_centi, {FullScaleShift{1'b0}}});
    assign lo_bound = $signed({lo_centi[15], lo_centi, {FullScaleShift{1'b0}}});
    assign in_window = (scaled <= hi_bound) && (scaled >= lo_bound);

    // Zero rate never qualifies
    assign sign_ok = rate_sign_reg ? (!item_reg.rate_raw[15] && (item_reg.rate_raw != 16'sd0))
                                   : item_reg.rate_raw[15];

    assign lockout_dec = (lockout_reg != '0) ? lockout_reg - MsWidth'(1) : lockout_reg;

    // Trigger and lockout update
    always_comb
    begin
        armed_next   = armed_reg;
        lockout_next = lockout_reg;
        fire         = 1'b0;
        if (item_reg.command == CmdTick)
        begin
            if (!armed_reg)
            begin
                lockout_next = lockout_dec;
                if (lockout_dec == '0)
                    armed_next = 1'b1;
            end
        end
        else if (armed_reg && sign_ok && in_window)
        begin
            fire         = 1'b1;
            armed_next   = 1'b0;
            lockout_next = rearm_reg;
        end
        result_next.fire      = fire;
        result_next.armed_now = armed_next;
    end

    // Item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!sample_stall)
            item_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            item_reg <= sample;
    end

    // State and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b1;
            lockout_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (item_advance)
        begin
            result_valid_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                armed_reg   <= armed_next;
                lockout_reg <= lockout_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_advance && item_valid_reg)
            result_reg <= result_next;
    end

    // Checks
    `AWTL_ASSERT_NOW(a_fire_disarms, clk, rst_n,
        result_valid && result.fire, !result.armed_now)
    `AWTL_ASSERT_NOW(a_armed_no_lockout, clk, rst_n,
        armed_reg, lockout_reg == '0)
    `AWTL_ASSERT_NOW(a_rearm_floor, clk, rst_n,
        1'b1, rearm_reg >= RearmMin)
    `AWTL_ASSERT_NEXT(a_disarm_loads, clk, rst_n,
        armed_reg && item_valid_reg && item_advance && fire, lockout_reg >= RearmMin)
    `AWTL_ASSERT_NEXT(a_result_tracks_state, clk, rst_n,
        item_valid_reg && item_advance, result.armed_now == armed_reg)

endmodule
